@@ rtl/core/rtfp_pkg.sv @@
`timescale 1ns / 1ps

package rtfp_pkg;

	localparam int FRAME_LEN = 26;
	localparam int NUM_CELLS = FRAME_LEN - 1;
	localparam int NUM_WORDS = 12;
	localparam int IDX_W     = 5;
	localparam int HDR_W     = 2;

	localparam logic [15:0] IDLE_LIMIT_RST = 16'd200;
	localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

	localparam logic [7:0] TAIL_LO = 8'h55;
	localparam logic [7:0] TAIL_HI = 8'hCC;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [HDR_W-1:0] HDR_LAST  = 2'd3;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);

	function automatic logic [7:0] header_byte(input logic [HDR_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'hAA;
			2'd1: b = 8'hFF;
			2'd2: b = 8'h03;
			2'd3: b = 8'h00;
			default: b = 8'hAA;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/core/rtfp_cell.sv @@
`timescale 1ns / 1ps

module rtfp_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

@@ rtl/core/radar_target_frame_parser.sv @@
`timescale 1ns / 1ps
// channel | signals                          | accepted when
// in      | in_valid, in_stall, func, rx_byte | in_valid && !in_stall
// out     | out_valid, out_stall, t1..t3_*    | out_valid && !out_stall
// cfg     | cfg_wr_en, cfg_wr_data           | cfg_wr_en
//
// One request per cycle when not stalled; a completed frame shows up on out
// the cycle after its last payload byte is taken, via the output register.
// Payload bytes move along a row of 25 byte cells; the 26th byte is checked
// on the fly and never stored.
// arst_n clears the control state and sets idle_limit to 200.
// in_stall rises only when the result register is held and the next byte
// would close a frame.

module radar_target_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] t1_x,
	output logic [15:0] t1_y,
	output logic [15:0] t1_speed,
	output logic [15:0] t1_res,
	output logic [15:0] t2_x,
	output logic [15:0] t2_y,
	output logic [15:0] t2_speed,
	output logic [15:0] t2_res,
	output logic [15:0] t3_x,
	output logic [15:0] t3_y,
	output logic [15:0] t3_speed,
	output logic [15:0] t3_res,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [15:0] idle_limit_q;
	logic [rtfp_pkg::HDR_W-1:0] hdr_q;
	logic in_frame_q;
	logic [rtfp_pkg::IDX_W-1:0] idx_q;
	logic [15:0] idle_q;
	logic activity_q;
	logic out_valid_q;
	logic [15:0] word_q [rtfp_pkg::NUM_WORDS];

	logic [7:0] cell_q [rtfp_pkg::NUM_CELLS];

	logic in_acc, is_byte, is_tick, last_byte, tail_ok, emit, shift_en;
	logic [15:0] tick_inc;

	assign in_acc    = in_valid && !in_stall;
	assign is_byte   = in_acc && (func == rtfp_pkg::FUNC_BYTE);
	assign is_tick   = in_acc && (func == rtfp_pkg::FUNC_TICK);
	assign last_byte = in_frame_q && (idx_q == rtfp_pkg::IDX_LAST);
	assign tail_ok   = (cell_q[rtfp_pkg::NUM_CELLS-1] == rtfp_pkg::TAIL_LO)
		&& (rx_byte == rtfp_pkg::TAIL_HI);
	assign emit      = is_byte && last_byte && tail_ok;
	assign shift_en  = is_byte && in_frame_q && !last_byte;
	assign in_stall  = out_valid_q && out_stall && last_byte;
	assign tick_inc  = (idle_q == rtfp_pkg::TICKS_MAX) ? idle_q : idle_q + 16'd1;

	// newest byte enters the top cell, older bytes move down one cell
	for (genvar i = 0; i < rtfp_pkg::NUM_CELLS; i++) begin : g_cell
		rtfp_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        ((i == rtfp_pkg::NUM_CELLS - 1) ? rx_byte : cell_q[(i + 1) % rtfp_pkg::NUM_CELLS]),
			.q        (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= rtfp_pkg::IDLE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			idle_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q      <= '0;
			in_frame_q <= 1'b0;
			idx_q      <= '0;
			idle_q     <= '0;
			activity_q <= 1'b0;
		end else if (is_tick) begin
			if (activity_q) begin
				if (tick_inc > idle_limit_q) begin
					hdr_q      <= '0;
					in_frame_q <= 1'b0;
					idx_q      <= '0;
					idle_q     <= '0;
					activity_q <= 1'b0;
				end else begin
					idle_q <= tick_inc;
				end
			end
		end else if (is_byte) begin
			activity_q <= !last_byte;
			idle_q     <= '0;
			if (in_frame_q) begin
				if (last_byte) begin
					in_frame_q <= 1'b0;
					idx_q      <= '0;
					hdr_q      <= '0;
				end else begin
					idx_q <= idx_q + rtfp_pkg::IDX_W'(1);
				end
			end else if (rx_byte == rtfp_pkg::header_byte(hdr_q)) begin
				if (hdr_q == rtfp_pkg::HDR_LAST) begin
					hdr_q      <= '0;
					in_frame_q <= 1'b1;
					idx_q      <= '0;
				end else begin
					hdr_q <= hdr_q + rtfp_pkg::HDR_W'(1);
				end
			end else begin
				hdr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// little-endian words from cells 0..23; the top cell holds byte 24
	always_ff @(posedge clk) begin
		if (emit) begin
			for (int k = 0; k < rtfp_pkg::NUM_WORDS; k++) begin
				word_q[k] <= {cell_q[2*k+1], cell_q[2*k]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign t1_x      = word_q[0];
	assign t1_y      = word_q[1];
	assign t1_speed  = word_q[2];
	assign t1_res    = word_q[3];
	assign t2_x      = word_q[4];
	assign t2_y      = word_q[5];
	assign t2_speed  = word_q[6];
	assign t2_res    = word_q[7];
	assign t3_x      = word_q[8];
	assign t3_y      = word_q[9];
	assign t3_speed  = word_q[10];
	assign t3_res    = word_q[11];

	a_frame_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (hdr_q == '0))
		else $error("header count not cleared inside a frame");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (idx_q == '0))
		else $error("byte index nonzero outside a frame");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("good frame produced no result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && last_byte))
		else $error("input stalled without a held result");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!activity_q |-> (idle_q == '0))
		else $error("idle count running without activity");

endmodule
